@@ rtl/rksu_pkg.sv @@
// ----------------------------------------------------------------------------
// rksu_pkg
// shared types of the render item key sorter
// ----------------------------------------------------------------------------
`default_nettype none

package rksu_pkg;

  localparam int unsigned KeyWidth = 32;

  // one draw item as held in the store
  typedef struct packed {
    logic                kind;
    logic [KeyWidth-1:0] material;
    logic [KeyWidth-1:0] mesh;
    logic [KeyWidth-1:0] depth;
    logic [KeyWidth-1:0] index;
    logic [KeyWidth-1:0] generation;
  } item_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/rksu_ram.sv @@
// ----------------------------------------------------------------------------
// rksu_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rksu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/rksu_cmp.sv @@
// ----------------------------------------------------------------------------
// rksu_cmp
// item order compare: high when item a must go strictly before item b
// ----------------------------------------------------------------------------
`default_nettype none

module rksu_cmp (
  input  wire rksu_pkg::item_t a,
  input  wire rksu_pkg::item_t b,
  output logic                 a_first
);
  import rksu_pkg::*;

  // nan has an all-ones exponent and a nonzero mantissa
  function automatic logic is_nan(input logic [KeyWidth-1:0] v);
    return v[KeyWidth-2:0] > 31'h7F80_0000;
  endfunction

  // monotone unsigned key, both zeros alike
  function automatic logic [KeyWidth-1:0] dkey(input logic [KeyWidth-1:0] v);
    logic [KeyWidth-1:0] w;
    w = (v == 32'h8000_0000) ? '0 : v;
    return w[KeyWidth-1] ? ~w : (w | 32'h8000_0000);
  endfunction

  logic                an, bn;
  logic [KeyWidth-1:0] ka, kb;
  logic                d_lt, d_eq;
  logic                mat_lt, mat_eq, mesh_lt, mesh_eq;
  logic                tail_lt;

  always_comb begin
    an      = is_nan(a.depth);
    bn      = is_nan(b.depth);
    ka      = dkey(a.depth);
    kb      = dkey(b.depth);
    // nan goes last in both queues
    if (an) begin
      d_lt = 1'b0;
    end else if (bn) begin
      d_lt = 1'b1;
    end else begin
      d_lt = a.kind ? (ka > kb) : (ka < kb);
    end
    d_eq    = (an && bn) || (!an && !bn && ka == kb);
    mat_lt  = a.material < b.material;
    mat_eq  = a.material == b.material;
    mesh_lt = a.mesh < b.mesh;
    mesh_eq = a.mesh == b.mesh;
    tail_lt = (a.index < b.index) ||
              (a.index == b.index && a.generation < b.generation);
    if (a.kind != b.kind) begin
      a_first = b.kind;
    end else if (!a.kind) begin
      a_first = mat_lt || (mat_eq && (mesh_lt || (mesh_eq &&
                (d_lt || (d_eq && tail_lt)))));
    end else begin
      a_first = d_lt || (d_eq && (mat_lt || (mat_eq &&
                (mesh_lt || (mesh_eq && tail_lt)))));
    end
  end

endmodule

`default_nettype wire

@@ rtl/render_item_key_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// render_item_key_sorter_unit
// collects a batch of draw items and emits it sorted by render key
// ----------------------------------------------------------------------------
// sorting: the final word of a batch of n stored items starts n selection
//   passes, each a scan of the stored items through the item ram followed by
//   one output word; an output word is held while out_stall is high
// throughput: one input word a cycle while loading; no input during sorting
// the single compare unit and the one read port of the item ram set the pace
// reset: synchronous, clears fill count, drop flag and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module render_item_key_sorter_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        queue_kind,
  input  wire logic [31:0] material_id,
  input  wire logic [31:0] mesh_id,
  input  wire logic [31:0] view_depth,
  input  wire logic [31:0] entity_index,
  input  wire logic [31:0] entity_generation,
  input  wire logic        batch_end,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_queue_kind,
  output logic      [31:0] out_material_id,
  output logic      [31:0] out_mesh_id,
  output logic      [31:0] out_view_depth,
  output logic      [31:0] out_entity_index,
  output logic      [31:0] out_entity_generation,
  output logic             overflowed,
  output logic             run_end
);
  import rksu_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_t          state;
  logic [CW-1:0]   fill;        // stored items, frozen while sorting
  logic            drop;        // a word of this batch was dropped
  logic [CW-1:0]   issue_cnt;   // next ram read of the current pass
  logic            rvalid;      // ram read data valid this cycle
  logic [AW-1:0]   raddr;       // address of that read data
  logic [CAPACITY-1:0] done;    // entries already emitted
  logic            have_best;
  item_t           best;
  logic [AW-1:0]   best_idx;
  logic [CW-1:0]   emit_cnt;

  item_t           in_item;
  item_t           rd_item;
  logic            rd_first;
  logic            in_take;
  logic            out_take;
  logic            wr_en;
  logic            issue;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign wr_en    = in_take && (fill < CapCount);
  assign issue    = (state == ST_SCAN) && (issue_cnt < fill);

  always_comb begin
    in_item.kind       = queue_kind;
    in_item.material   = material_id;
    in_item.mesh       = mesh_id;
    in_item.depth      = view_depth;
    in_item.index      = entity_index;
    in_item.generation = entity_generation;
  end

  rksu_ram #(
    .WIDTH($bits(item_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill[AW-1:0]),
    .wr_data(in_item),
    .rd_addr(issue_cnt[AW-1:0]),
    .rd_data(rd_item)
  );

  // shared compare unit: read word against the best so far
  rksu_cmp u_cmp (
    .a      (rd_item),
    .b      (best),
    .a_first(rd_first)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      drop      <= 1'b0;
      issue_cnt <= '0;
      rvalid    <= 1'b0;
      have_best <= 1'b0;
      emit_cnt  <= '0;
      done      <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (wr_en) begin
              fill <= fill + 1'b1;
            end else begin
              drop <= 1'b1;
            end
            // a batch always holds at least one item here
            if (batch_end) begin
              state     <= ST_SCAN;
              issue_cnt <= '0;
              rvalid    <= 1'b0;
              have_best <= 1'b0;
              emit_cnt  <= '0;
              done      <= '0;
            end
          end
        end
        ST_SCAN: begin
          rvalid <= issue;
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          // lowest pending item wins; strict compare keeps arrival order
          if (rvalid && !done[raddr] && (!have_best || rd_first)) begin
            have_best <= 1'b1;
            best_idx  <= raddr;
          end
          if (!issue && !rvalid) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_take) begin
            done[best_idx] <= 1'b1;
            emit_cnt       <= emit_cnt + 1'b1;
            if (run_end) begin
              state <= ST_LOAD;
              fill  <= '0;
              drop  <= 1'b0;
            end else begin
              state     <= ST_SCAN;
              issue_cnt <= '0;
              have_best <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    raddr <= issue_cnt[AW-1:0];
    if (state == ST_SCAN && rvalid && !done[raddr] && (!have_best || rd_first)) begin
      best <= rd_item;
    end
  end

  assign in_stall              = (state != ST_LOAD);
  assign out_valid             = (state == ST_EMIT);
  assign out_queue_kind        = best.kind;
  assign out_material_id       = best.material;
  assign out_mesh_id           = best.mesh;
  assign out_view_depth        = best.depth;
  assign out_entity_index      = best.index;
  assign out_entity_generation = best.generation;
  assign overflowed            = drop;
  assign run_end               = (CW'(emit_cnt + 1'b1) == fill);

endmodule

`default_nettype wire
